// ===== rtl/rha_pkg.sv =====
// Shared types, constants and codes for the reference-counted handle allocator.
package rha_pkg;

  localparam int NUM_BUCKETS = 16;
  localparam int SLOTS_PER_BUCKET = 256;
  localparam int BUCKET_W = $clog2(NUM_BUCKETS);
  localparam int SLOT_W = $clog2(SLOTS_PER_BUCKET);
  localparam int HANDLE_W = BUCKET_W + SLOT_W;
  localparam int ENTRIES = NUM_BUCKETS * SLOTS_PER_BUCKET;
  localparam int CNT_W = SLOT_W + 1;
  localparam int REF_W = 16;
  localparam int GEN_W = 64;
  localparam logic [REF_W-1:0] REF_MAX = '1;
  localparam logic [CNT_W-1:0] MAX_SLOTS_RST = CNT_W'(SLOTS_PER_BUCKET);

  // Request opcodes
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_ADDREF = 3'd1;
  localparam logic [2:0] OP_DROP = 3'd2;
  localparam logic [2:0] OP_CLRTXN = 3'd3;
  localparam logic [2:0] OP_QUERY = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_UNREF = 2'd2;

  typedef struct packed {
    logic [2:0]          op;
    logic [7:0]          cpu_id;
    logic [7:0]          node_id;
    logic                has_txn;
    logic [HANDLE_W-1:0] entry_handle;
    logic [GEN_W-1:0]    generation;
    logic                generation_none;
  } req_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [HANDLE_W-1:0] new_handle;
    logic [GEN_W-1:0]    entry_generation;
    logic                entry_generation_none;
    logic                txn_active;
    logic                was_freed;
  } rsp_t;

  // One word of the per-entry metadata memory
  typedef struct packed {
    logic [REF_W-1:0] ref_cnt;
    logic             txn;
    logic             gen_none;
  } ent_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_CLEAR, ST_ALLOC, ST_LINK, ST_READ, ST_EXEC
  } state_t;

  typedef struct packed {
    logic latch_req;
    logic clr_step;
    logic do_alloc;
    logic do_link;
    logic do_exec;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic req_alloc;
  } sts_t;

endpackage

// ===== rtl/rha_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/rha_ctrl.sv =====
// Controller state machine: sequences clearing, allocation and entry updates.
module rha_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  rha_pkg::sts_t sts,
  output rha_pkg::cmd_t cmd,
  output logic          busy
);
  import rha_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          state_nxt = sts.req_alloc ? ST_ALLOC : ST_READ;
        end
      end
      ST_CLEAR: begin
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_ALLOC: state_nxt = ST_LINK;
      ST_LINK:  state_nxt = ST_IDLE;
      ST_READ:  state_nxt = ST_EXEC;
      ST_EXEC:  state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd = '0;
    busy = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        busy = 1'b0;
        cmd.latch_req = start;
      end
      ST_CLEAR: cmd.clr_step = 1'b1;
      ST_ALLOC: cmd.do_alloc = 1'b1;
      ST_LINK:  cmd.do_link = 1'b1;
      ST_READ:  ;
      ST_EXEC:  cmd.do_exec = 1'b1;
      default:  ;
    endcase
  end

  a_reset_clears: assert property (@(posedge clk)
    $past(!rst_n) && rst_n |-> state_r == ST_CLEAR)
    else $error("controller did not enter clearing after reset");
  a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.clr_step, cmd.do_alloc, cmd.do_link, cmd.do_exec}))
    else $error("more than one datapath command at once");
  a_alloc_link: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.do_alloc |=> cmd.do_link)
    else $error("allocation not followed by link step");

endmodule

// ===== rtl/rha_dp.sv =====
// Datapath: bucket state, entry memories, probe pick and result register.
module rha_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  rha_pkg::cmd_t         cmd,
  output rha_pkg::sts_t         sts,
  input  rha_pkg::req_t         in_req,
  input  logic                  cfg_valid,
  input  logic [rha_pkg::CNT_W-1:0] cfg_data,
  output logic                  out_valid,
  output rha_pkg::rsp_t         out_rsp
);
  import rha_pkg::*;

  req_t                req_r;
  logic [CNT_W-1:0]    max_slots_r;
  logic [SLOT_W-1:0]   head_r [NUM_BUCKETS];
  logic [CNT_W-1:0]    cnt_r [NUM_BUCKETS];
  logic [CNT_W-1:0]    bump_r [NUM_BUCKETS];
  logic [HANDLE_W-1:0] clr_r;
  logic                out_valid_r;
  rsp_t                out_rsp_r;
  // allocation bookkeeping between the probe and link steps
  logic                alloc_ok_r;
  logic [HANDLE_W-1:0] alloc_e_r;
  logic                pop_upd_r;
  logic [BUCKET_W-1:0] pop_b_r;

  logic [CNT_W-1:0]    limit;
  logic [NUM_BUCKETS-1:0] avail;
  logic [BUCKET_W-1:0] start_b;
  logic [2*NUM_BUCKETS-1:0] rot2;
  logic [NUM_BUCKETS-1:0] rot;
  logic                any_avail;
  logic [BUCKET_W-1:0] pick_off;
  logic [BUCKET_W-1:0] pick_b;
  logic                pick_pop;
  logic [SLOT_W-1:0]   pick_slot;

  // memory ports
  logic                ent_we;
  logic [HANDLE_W-1:0] ent_waddr;
  ent_t                ent_wdata, ent_rdata;
  logic                gen_we;
  logic [GEN_W-1:0]    gen_wdata, gen_rdata;
  logic                lnk_we;
  logic [SLOT_W-1:0]   lnk_wdata, lnk_rdata;
  logic [HANDLE_W-1:0] lnk_raddr;

  // execute-step values
  logic [BUCKET_W-1:0] ex_b;
  ent_t                ex_ent;
  logic [GEN_W-1:0]    ex_gen;
  logic                ex_freed;
  logic                ex_upd_gen;
  rsp_t                ex_rsp;
  rsp_t                alloc_rsp;

  assign sts.clr_done = (clr_r == HANDLE_W'(ENTRIES - 1));
  assign sts.req_alloc = (in_req.op == OP_ALLOC);

  assign limit = (max_slots_r > MAX_SLOTS_RST) ? MAX_SLOTS_RST : max_slots_r;
  assign start_b = {req_r.node_id[0], req_r.cpu_id[BUCKET_W-1:1]};

  // bucket availability and rotated priority pick from the start bucket
  always_comb begin
    for (int b = 0; b < NUM_BUCKETS; b++) begin
      avail[b] = (cnt_r[b] != '0) || (bump_r[b] < limit);
    end
    rot2 = {avail, avail} >> start_b;
    rot = rot2[NUM_BUCKETS-1:0];
    any_avail = |rot;
    pick_off = '0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if (rot[i]) begin
        pick_off = BUCKET_W'(i);
      end
    end
    pick_b = start_b + pick_off;
    pick_pop = (cnt_r[pick_b] != '0);
    pick_slot = pick_pop ? head_r[pick_b] : bump_r[pick_b][SLOT_W-1:0];
  end

  assign lnk_raddr = {pick_b, head_r[pick_b]};

  // execute step: update the addressed entry from the read data
  always_comb begin
    ex_b = req_r.entry_handle[HANDLE_W-1:SLOT_W];
    ex_ent = ent_rdata;
    ex_gen = gen_rdata;
    ex_freed = 1'b0;
    ex_upd_gen = 1'b0;
    ex_rsp = '0;
    if (req_r.op == OP_ADDREF || req_r.op == OP_DROP || req_r.op == OP_CLRTXN ||
        req_r.op == OP_QUERY) begin
      if (req_r.op != OP_QUERY && ent_rdata.ref_cnt == '0) begin
        ex_rsp.status = ST_UNREF;
      end else if (req_r.op == OP_ADDREF) begin
        if (req_r.generation_none) begin
          if (ent_rdata.ref_cnt != REF_MAX) ex_ent.ref_cnt = ent_rdata.ref_cnt + 1'b1;
        end else if (ent_rdata.gen_none || gen_rdata != req_r.generation) begin
          if (ent_rdata.ref_cnt != REF_MAX) ex_ent.ref_cnt = ent_rdata.ref_cnt + 1'b1;
          ex_ent.gen_none = 1'b0;
          ex_gen = req_r.generation;
          ex_upd_gen = 1'b1;
        end
      end else if (req_r.op == OP_DROP || req_r.op == OP_CLRTXN) begin
        if (req_r.op == OP_CLRTXN) ex_ent.txn = 1'b0;
        ex_ent.ref_cnt = ent_rdata.ref_cnt - 1'b1;
        ex_freed = (ex_ent.ref_cnt == '0);
      end
      ex_rsp.entry_generation_none = ex_ent.gen_none;
      ex_rsp.entry_generation = ex_ent.gen_none ? '0 : ex_gen;
      ex_rsp.txn_active = ex_ent.txn;
      ex_rsp.was_freed = ex_freed;
    end
  end

  // allocation result: new handle, or all buckets full
  always_comb begin
    alloc_rsp = '0;
    if (alloc_ok_r) begin
      alloc_rsp.new_handle = alloc_e_r;
      alloc_rsp.entry_generation_none = 1'b1;
      alloc_rsp.txn_active = req_r.has_txn;
    end else begin
      alloc_rsp.status = ST_FULL;
    end
  end

  // memory write port selection
  always_comb begin
    ent_we = 1'b0;
    ent_waddr = clr_r;
    ent_wdata = '{ref_cnt: '0, txn: 1'b0, gen_none: 1'b1};
    if (cmd.clr_step) begin
      ent_we = 1'b1;
    end else if (cmd.do_alloc) begin
      ent_we = any_avail;
      ent_waddr = {pick_b, pick_slot};
      ent_wdata = '{ref_cnt: REF_W'(1), txn: req_r.has_txn, gen_none: 1'b1};
    end else if (cmd.do_exec) begin
      ent_we = 1'b1;
      ent_waddr = req_r.entry_handle;
      ent_wdata = ex_ent;
    end
    gen_we = cmd.do_exec && ex_upd_gen;
    gen_wdata = ex_gen;
    lnk_we = cmd.do_exec && ex_freed;
    lnk_wdata = (cnt_r[ex_b] != '0) ? head_r[ex_b] : '0;
  end

  rha_ram #(.WIDTH($bits(ent_t)), .DEPTH(ENTRIES)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_waddr), .wdata(ent_wdata),
    .raddr(req_r.entry_handle), .rdata(ent_rdata)
  );

  rha_ram #(.WIDTH(GEN_W), .DEPTH(ENTRIES)) u_gen_ram (
    .clk(clk), .we(gen_we), .waddr(req_r.entry_handle), .wdata(gen_wdata),
    .raddr(req_r.entry_handle), .rdata(gen_rdata)
  );

  rha_ram #(.WIDTH(SLOT_W), .DEPTH(ENTRIES)) u_lnk_ram (
    .clk(clk), .we(lnk_we), .waddr(req_r.entry_handle), .wdata(lnk_wdata),
    .raddr(lnk_raddr), .rdata(lnk_rdata)
  );

  // request and allocation payload registers
  always_ff @(posedge clk) begin
    if (cmd.latch_req) req_r <= in_req;
    if (cmd.do_alloc) begin
      alloc_e_r <= {pick_b, pick_slot};
      pop_b_r <= pick_b;
    end
  end

  // control state: register, bucket lists, clearing counter, result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_slots_r <= MAX_SLOTS_RST;
      clr_r <= '0;
      out_valid_r <= 1'b0;
      alloc_ok_r <= 1'b0;
      pop_upd_r <= 1'b0;
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head_r[b] <= '0;
        cnt_r[b] <= '0;
        bump_r[b] <= '0;
      end
    end else begin
      if (cfg_valid) max_slots_r <= cfg_data;
      if (cmd.clr_step) clr_r <= clr_r + 1'b1;
      out_valid_r <= cmd.do_link || cmd.do_exec;
      if (cmd.do_alloc) begin
        alloc_ok_r <= any_avail;
        pop_upd_r <= any_avail && pick_pop && (cnt_r[pick_b] != CNT_W'(1));
        if (any_avail) begin
          if (pick_pop) cnt_r[pick_b] <= cnt_r[pick_b] - 1'b1;
          else bump_r[pick_b] <= bump_r[pick_b] + 1'b1;
        end
      end
      if (cmd.do_link && pop_upd_r) head_r[pop_b_r] <= lnk_rdata;
      if (cmd.do_exec && ex_freed) begin
        head_r[ex_b] <= req_r.entry_handle[SLOT_W-1:0];
        cnt_r[ex_b] <= cnt_r[ex_b] + 1'b1;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.do_link) begin
      out_rsp_r <= alloc_rsp;
    end else if (cmd.do_exec) begin
      out_rsp_r <= ex_rsp;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp = out_rsp_r;

  a_strobe_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.do_link) || $past(cmd.do_exec))
    else $error("result strobe without a finishing step");
  a_full_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.status == ST_FULL |-> out_rsp_r.new_handle == '0)
    else $error("full result carries a handle");
  a_freed_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rsp_r.was_freed |-> out_rsp_r.status == ST_OK)
    else $error("entry freed on an error result");

endmodule

// ===== rtl/refcounted_handle_allocator.sv =====
// Top level of the reference-counted handle allocator.
// After reset the block sweeps its 4096-entry metadata memory, one entry a
// cycle, holding busy high until the sweep ends; max_slots may be written
// then too. A request passes through probe and pick, then free-list link
// update for allocate, or entry memory read, then update for the others, set
// by the registered read of the entry memories; no new request is taken until
// the block is back in idle. The result appears on out_rsp with out_valid high
// for exactly one cycle and cannot be held off.
module refcounted_handle_allocator (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  rha_pkg::req_t             in_req,
  output logic                      out_valid,
  output rha_pkg::rsp_t             out_rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [rha_pkg::CNT_W-1:0] cfg_data
);
  import rha_pkg::*;

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready = 1'b1;

  rha_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .sts(sts), .cmd(cmd), .busy(busy)
  );

  rha_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_req(in_req),
    .cfg_valid(cfg_valid), .cfg_data(cfg_data),
    .out_valid(out_valid), .out_rsp(out_rsp)
  );

endmodule

// ===== tb/rha_checker.sv =====
// Checker for the handle allocator: predicts each response and compares it.
module rha_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic                       busy,
  input  rha_pkg::req_t              in_req,
  input  logic                       out_valid,
  input  rha_pkg::rsp_t              out_rsp,
  input  logic                       cfg_valid,
  input  logic                       cfg_ready,
  input  logic [rha_pkg::CNT_W-1:0]  cfg_data,
  output int                         mismatches,
  output int                         outstanding
);
  import rha_pkg::*;

  // Shadow of the allocator state
  int unsigned            slot_limit;
  logic [SLOT_W-1:0]      head_slot [NUM_BUCKETS];
  int unsigned            list_len [NUM_BUCKETS];
  int unsigned            bumped [NUM_BUCKETS];
  logic [SLOT_W-1:0]      link_slot [ENTRIES];
  logic [REF_W-1:0]       refs [ENTRIES];
  logic                   txn_bit [ENTRIES];
  logic [GEN_W-1:0]       gen_val [ENTRIES];
  logic                   gen_invalid [ENTRIES];

  rsp_t responses_due [$];

  assign outstanding = responses_due.size();

  function automatic void report_entry(int e, ref rsp_t o);
    o.entry_generation_none = gen_invalid[e];
    o.entry_generation = gen_invalid[e] ? '0 : gen_val[e];
    o.txn_active = txn_bit[e];
  endfunction

  // Apply one request to the shadow state and return the response it causes
  function automatic rsp_t apply_request(req_t r);
    rsp_t o;
    int   b;
    int   e;
    int   slot;
    bit   got;
    o = '0;
    got = 0;
    case (r.op)
      OP_ALLOC: begin
        b = (r.node_id % 2) * (NUM_BUCKETS / 2) + (r.cpu_id / 2) % (NUM_BUCKETS / 2);
        for (int tries = 0; tries < NUM_BUCKETS && !got; tries++) begin
          if (list_len[b] > 0) begin
            slot = head_slot[b];
            list_len[b]--;
            if (list_len[b] > 0) head_slot[b] = link_slot[b * SLOTS_PER_BUCKET + slot];
            got = 1;
          end else if (bumped[b] < slot_limit) begin
            slot = bumped[b];
            bumped[b]++;
            got = 1;
          end else begin
            b = (b + 1) % NUM_BUCKETS;
          end
        end
        if (got) begin
          e = b * SLOTS_PER_BUCKET + slot;
          txn_bit[e] = r.has_txn;
          gen_val[e] = '0;
          gen_invalid[e] = 1'b1;
          refs[e] = 1;
          o.new_handle = HANDLE_W'(e);
          report_entry(e, o);
        end else begin
          o.status = ST_FULL;
        end
      end
      OP_ADDREF, OP_DROP, OP_CLRTXN, OP_QUERY: begin
        e = r.entry_handle;
        if (r.op == OP_QUERY) begin
          report_entry(e, o);
        end else if (refs[e] == 0) begin
          o.status = ST_UNREF;
          report_entry(e, o);
        end else if (r.op == OP_ADDREF) begin
          if (r.generation_none) begin
            if (refs[e] != REF_MAX) refs[e]++;
          end else if (gen_invalid[e] || gen_val[e] != r.generation) begin
            if (refs[e] != REF_MAX) refs[e]++;
            gen_val[e] = r.generation;
            gen_invalid[e] = 1'b0;
          end
          report_entry(e, o);
        end else begin
          if (r.op == OP_CLRTXN) txn_bit[e] = 1'b0;
          refs[e]--;
          if (refs[e] == 0) begin
            b = e / SLOTS_PER_BUCKET;
            link_slot[e] = list_len[b] > 0 ? head_slot[b] : '0;
            head_slot[b] = SLOT_W'(e % SLOTS_PER_BUCKET);
            list_len[b]++;
            o.was_freed = 1'b1;
          end
          report_entry(e, o);
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  always @(posedge clk) begin
    rsp_t want;
    bit   bad;
    if (!rst_n) begin
      slot_limit = SLOTS_PER_BUCKET;
      mismatches = 0;
      responses_due.delete();
      for (int b = 0; b < NUM_BUCKETS; b++) begin
        head_slot[b] = '0;
        list_len[b] = 0;
        bumped[b] = 0;
      end
      for (int e = 0; e < ENTRIES; e++) begin
        link_slot[e] = '0;
        refs[e] = '0;
        txn_bit[e] = 1'b0;
        gen_val[e] = '0;
        gen_invalid[e] = 1'b1;
      end
    end else begin
      if (cfg_valid && cfg_ready)
        slot_limit = cfg_data > SLOTS_PER_BUCKET ? SLOTS_PER_BUCKET : cfg_data;
      if (start && !busy) responses_due.push_back(apply_request(in_req));
      // Compare each response with the oldest one due
      if (out_valid) begin
        if (responses_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected response %p", out_rsp);
        end else begin
          want = responses_due.pop_front();
          bad = want.status != out_rsp.status
             || want.new_handle != out_rsp.new_handle
             || want.entry_generation != out_rsp.entry_generation
             || want.entry_generation_none != out_rsp.entry_generation_none
             || want.txn_active != out_rsp.txn_active
             || want.was_freed != out_rsp.was_freed;
          if (bad) begin
            mismatches++;
            if (mismatches <= 10) $display("response wrong: expected %p got %p", want, out_rsp);
          end
        end
      end
    end
  end

endmodule

// ===== tb/tb.sv =====
// Testbench top for the handle allocator: stimulus, clock, reset and verdict.
module tb;
  import rha_pkg::*;

  localparam logic [2:0] OP_SPARE_LO = 3'd5;
  localparam logic [2:0] OP_SPARE_HI = 3'd7;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  req_t             in_req = '0;
  logic             out_valid;
  rsp_t             out_rsp;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [CNT_W-1:0] cfg_data = '0;
  int               mismatches;
  int               outstanding;
  bit               idling = 1'b1;

  always #5 clk = ~clk;

  refcounted_handle_allocator i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  rha_checker i_checker (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_req(in_req),
    .out_valid(out_valid), .out_rsp(out_rsp),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .mismatches(mismatches), .outstanding(outstanding)
  );

  // Present one request and hold it until accepted
  task automatic send(req_t r);
    start <= 1'b1;
    in_req <= r;
    do @(posedge clk); while (busy);
    if (idling && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  // Stop sending and wait for every response due, then let the pipe settle
  task automatic drain();
    start <= 1'b0;
    repeat (2) @(negedge clk);
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_max_slots(logic [CNT_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [HANDLE_W-1:0] pick_handle();
    if ($urandom_range(0, 9) == 0) return HANDLE_W'($urandom);
    return {BUCKET_W'($urandom_range(0, NUM_BUCKETS - 1)), SLOT_W'($urandom_range(0, 15))};
  endfunction

  function automatic req_t random_request();
    req_t r;
    int   pick;
    r.cpu_id = 8'($urandom);
    r.node_id = 8'($urandom);
    r.has_txn = 1'($urandom);
    r.entry_handle = pick_handle();
    r.generation_none = $urandom_range(0, 3) == 0;
    // a small pool of generations so repeats happen
    case ($urandom_range(0, 5))
      0: r.generation = '0;
      1: r.generation = '1;
      2: r.generation = 64'h8000_0000_0000_0001;
      default: r.generation = {$urandom, $urandom};
    endcase
    pick = $urandom_range(0, 99);
    if (pick < 30) r.op = OP_ALLOC;
    else if (pick < 50) r.op = OP_ADDREF;
    else if (pick < 75) r.op = OP_DROP;
    else if (pick < 85) r.op = OP_CLRTXN;
    else if (pick < 95) r.op = OP_QUERY;
    else r.op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    return r;
  endfunction

  function automatic req_t make_req(logic [2:0] op, logic [HANDLE_W-1:0] h);
    req_t r;
    r = '0;
    r.op = op;
    r.entry_handle = h;
    return r;
  endfunction

  initial begin
    req_t r;
    logic [CNT_W-1:0] phase_slots [5];
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part: one slot per bucket so the allocator fills up quickly
    write_max_slots(CNT_W'(1));
    r = make_req(OP_ALLOC, '0);
    r.has_txn = 1'b1;
    send(r);
    for (int i = 0; i < 16; i++) begin
      r = make_req(OP_ALLOC, '0);
      r.cpu_id = i == 0 ? 8'hFF : 8'($urandom);
      r.node_id = i == 0 ? 8'hFF : 8'($urandom);
      r.has_txn = i[0];
      send(r);
    end
    r = make_req(OP_ADDREF, '0);
    r.generation = '1;
    send(r);
    send(r);
    r.generation_none = 1'b1;
    send(r);
    send(make_req(OP_QUERY, '0));
    send(make_req(OP_CLRTXN, 12'h100));
    send(make_req(OP_DROP, 12'h100));
    send(make_req(OP_DROP, '1));
    send(make_req(OP_SPARE_HI, '1));
    send(make_req(OP_QUERY, 12'h100));
    send(make_req(OP_ALLOC, '0));
    drain();

    // Random phases over several slot limits; the last runs without gaps
    phase_slots[0] = CNT_W'(4);
    phase_slots[1] = '1;
    phase_slots[2] = CNT_W'(SLOTS_PER_BUCKET);
    phase_slots[3] = CNT_W'(2);
    phase_slots[4] = CNT_W'($urandom_range(1, 16));
    for (int p = 0; p < 5; p++) begin
      write_max_slots(phase_slots[p]);
      idling = p != 4;
      repeat (180) send(random_request());
      drain();
    end

    if (mismatches == 0) begin
      $display("refcounted_handle_allocator: match");
    end else begin
      $display("refcounted_handle_allocator: mismatch");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("refcounted_handle_allocator: mismatch");
    $finish;
  end

endmodule
